// ----- rtl/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the disk seek scheduler
// Word formats, chain cell entry, chain control and register/mode codes.
// ----------------------------------------------------------------------------
package dss_pkg;

    // field widths
    localparam int TRACK_BITS = 12;
    localparam int KEY_BITS   = TRACK_BITS + 1;
    localparam int SEEK_BITS  = 18;

    // default request buffer depth
    localparam int QUEUE_DEPTH_DEF = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_START_TRACK = 2'd0;
    localparam logic [1:0] CFG_SWEEP_UP    = 2'd1;
    localparam logic [1:0] CFG_ALGORITHM   = 2'd2;
    localparam logic [1:0] CFG_LAST_TRACK  = 2'd3;

    // scheduling algorithm codes
    localparam logic [1:0] ALG_FCFS = 2'd0;
    localparam logic [1:0] ALG_SCAN = 2'd1;
    localparam logic [1:0] ALG_LOOK = 2'd2;

    // input word
    typedef struct packed {
        logic [TRACK_BITS-1:0] track;
        logic                  final_req;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [TRACK_BITS-1:0] visited;
        logic [SEEK_BITS-1:0]  seek_total;
        logic                  end_of_batch;
        logic                  dropped;
    } out_word_t;

    // one cell of a chain: sort key plus the track it stands for
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [TRACK_BITS-1:0] track;
    } entry_t;

    // chain operation for one cycle (at most one set)
    typedef struct packed {
        logic push;    // shift up, new entry into cell 0
        logic insert;  // ordered insert of the new entry
        logic pop;     // shift down, cell 0 leaves
    } chain_ctl_t;

endpackage

// ----- rtl/disk_seek_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// disk_seek_scheduler_top: FCFS / SCAN / LOOK disk seek scheduler
// Serves FCFS requests at once, or buffers a SCAN / LOOK batch and plays back the visit order.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry request words (track, final_req);
//   out_valid/out_stall/out_data carry visit words. The cfg_we port writes
//   start_track, sweep_up, algorithm and last_track; the user must do so
//   only between batches, which the block itself does not enforce.
//   FCFS: one request per cycle, each visit word registered in the cycle
//   after its request; a waiting visit word holds the input only while
//   out_stall keeps the output register full.
//   SCAN / LOOK: requests load into a request stack (no output); those past
//   QUEUE_DEPTH are dropped. After the final request the stack is drained
//   into a sorted insertion chain, one request per cycle, then visit words
//   leave at one per cycle unless out_stall holds them: one word per stored
//   request plus the SCAN edge word when taken. Input is stalled from the
//   final request until the last visit word has entered the output register.
//   Reset empties both chains and the output register; registers return
//   to start_track 0, sweep_up 1, FCFS, last_track all ones. No clearing
//   pass is needed. Back pressure freezes the output register and playback,
//   and in FCFS also stalls the input.
// ----------------------------------------------------------------------------
module disk_seek_scheduler_top
    import dss_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [TRACK_BITS-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // saturating seek accumulate
    function automatic logic [SEEK_BITS-1:0] seek_add(
        input logic [SEEK_BITS-1:0]  s,
        input logic [TRACK_BITS-1:0] a,
        input logic [TRACK_BITS-1:0] b
    );
        logic [TRACK_BITS-1:0] d;
        logic [SEEK_BITS:0]    sum;
        d   = (a > b) ? (a - b) : (b - a);
        sum = {1'b0, s} + (SEEK_BITS + 1)'(d);
        return sum[SEEK_BITS] ? '1 : sum[SEEK_BITS-1:0];
    endfunction

    // configuration registers
    logic [TRACK_BITS-1:0] start_reg;
    logic                  sweep_up_reg;
    logic [1:0]            alg_reg;
    logic [TRACK_BITS-1:0] last_track_reg;

    // batch state
    logic [1:0]            state_reg,  state_next;
    logic                  open_reg,   open_next;
    logic [1:0]            mode_reg,   mode_next;
    logic [TRACK_BITS-1:0] head_reg,   head_next;
    logic [SEEK_BITS-1:0]  seek_reg,   seek_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic                  ovf_reg,    ovf_next;
    logic                  up_reg,     up_next;
    logic [TRACK_BITS-1:0] edge_reg,   edge_next;
    logic                  edone_reg,  edone_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_data_reg,  out_data_next;

    // chains
    chain_ctl_t            raw_ctl, srt_ctl;
    entry_t                raw_head, srt_head;
    logic                  raw_second, srt_second;
    logic [KEY_BITS-1:0]   srt_key;

    // per-item helpers
    logic                  can_load;
    logic                  in_acc;
    logic [1:0]            mode_now;
    logic                  buffered_now;
    logic [TRACK_BITS-1:0] eff_head;
    logic [SEEK_BITS-1:0]  eff_seek;
    logic [CNT_W-1:0]      eff_count;
    logic                  eff_ovf;
    logic                  is_scan;
    logic                  grp;
    logic                  edge_want;
    logic                  edge_after;

    assign can_load     = !out_valid_reg || !out_stall;
    assign mode_now     = open_reg ? mode_reg :
                          ((alg_reg == ALG_SCAN || alg_reg == ALG_LOOK) ? alg_reg : ALG_FCFS);
    assign buffered_now = (mode_now != ALG_FCFS);
    assign in_stall     = (state_reg != ST_LOAD) || (!buffered_now && !can_load);
    assign in_acc       = in_valid && !in_stall;

    // batch values as seen by the item at hand (a new batch starts fresh)
    assign eff_head  = open_reg ? head_reg  : start_reg;
    assign eff_seek  = open_reg ? seek_reg  : '0;
    assign eff_count = open_reg ? count_reg : '0;
    assign eff_ovf   = open_reg && ovf_reg;

    assign is_scan = (mode_reg == ALG_SCAN);

    // served-order key: first sweep group 0, then the reversed group 1
    always_comb
    begin
        if (up_reg)
            grp = (raw_head.track < head_reg);
        else
            grp = (raw_head.track > head_reg);
        srt_key = {grp, ((up_reg == grp) ? ~raw_head.track : raw_head.track)};
    end

    // SCAN edge still to visit from the current head / from the head track
    assign edge_want  = is_scan && !edone_reg &&
                        (up_reg ? (head_reg < edge_reg) : (head_reg != '0));
    assign edge_after = is_scan && !edone_reg &&
                        (up_reg ? (srt_head.track < edge_reg) : (srt_head.track != '0));

    // request stack and sorted chain
    dss_chain #(.DEPTH(QUEUE_DEPTH)) u_raw (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (raw_ctl),
        .new_key      ({1'b0, in_data.track}),
        .new_track    (in_data.track),
        .head         (raw_head),
        .second_valid (raw_second)
    );

    dss_chain #(.DEPTH(QUEUE_DEPTH)) u_srt (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (srt_ctl),
        .new_key      (srt_key),
        .new_track    (raw_head.track),
        .head         (srt_head),
        .second_valid (srt_second)
    );

    // control and datapath
    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        mode_next      = mode_reg;
        head_next      = head_reg;
        seek_next      = seek_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        up_next        = up_reg;
        edge_next      = edge_reg;
        edone_next     = edone_reg;
        raw_ctl        = '0;
        srt_ctl        = '0;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    open_next  = !in_data.final_req;
                    mode_next  = mode_now;
                    head_next  = eff_head;
                    seek_next  = eff_seek;
                    count_next = eff_count;
                    ovf_next   = eff_ovf;
                    if (!buffered_now)
                    begin
                        // FCFS: serve at once
                        head_next      = in_data.track;
                        seek_next      = seek_add(eff_seek, eff_head, in_data.track);
                        out_valid_next = 1'b1;
                        out_data_next  = '{visited:      in_data.track,
                                           seek_total:   seek_next,
                                           end_of_batch: in_data.final_req,
                                           dropped:      1'b0};
                    end
                    else
                    begin
                        if (eff_count < CNT_FULL)
                        begin
                            raw_ctl.push = 1'b1;
                            count_next   = eff_count + 1'b1;
                        end
                        else
                            ovf_next = 1'b1;
                        if (in_data.final_req)
                        begin
                            up_next    = sweep_up_reg;
                            edge_next  = last_track_reg;
                            edone_next = 1'b0;
                            state_next = ST_SORT;
                        end
                    end
                end
            end

            ST_SORT:
            begin
                // move one request per cycle into the sorted chain
                if (raw_head.valid)
                begin
                    raw_ctl.pop    = 1'b1;
                    srt_ctl.insert = 1'b1;
                    if (!raw_second)
                        state_next = ST_EMIT;
                end
                else
                    state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.dropped = ovf_reg;
                    if (srt_head.valid && !srt_head.key[KEY_BITS-1])
                    begin
                        // first sweep
                        srt_ctl.pop = 1'b1;
                        head_next   = srt_head.track;
                        seek_next   = seek_add(seek_reg, head_reg, srt_head.track);
                        out_data_next.visited      = srt_head.track;
                        out_data_next.seek_total   = seek_next;
                        out_data_next.end_of_batch = !srt_second && !edge_after;
                    end
                    else if (edge_want)
                    begin
                        // SCAN run to the disk edge
                        edone_next = 1'b1;
                        head_next  = up_reg ? edge_reg : '0;
                        seek_next  = seek_add(seek_reg, head_reg, head_next);
                        out_data_next.visited      = head_next;
                        out_data_next.seek_total   = seek_next;
                        out_data_next.end_of_batch = !srt_head.valid;
                    end
                    else
                    begin
                        // return sweep
                        edone_next  = 1'b1;
                        srt_ctl.pop = 1'b1;
                        head_next   = srt_head.track;
                        seek_next   = seek_add(seek_reg, head_reg, srt_head.track);
                        out_data_next.visited      = srt_head.track;
                        out_data_next.seek_total   = seek_next;
                        out_data_next.end_of_batch = !srt_second;
                    end
                    if (out_data_next.end_of_batch)
                        state_next = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= '0;
            sweep_up_reg   <= 1'b1;
            alg_reg        <= ALG_FCFS;
            last_track_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_TRACK: start_reg      <= cfg_wdata;
                CFG_SWEEP_UP:    sweep_up_reg   <= cfg_wdata[0];
                CFG_ALGORITHM:   alg_reg        <= cfg_wdata[1:0];
                CFG_LAST_TRACK:  last_track_reg <= cfg_wdata;
                default:         alg_reg        <= alg_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            open_reg      <= 1'b0;
            mode_reg      <= ALG_FCFS;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            edone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            edone_reg     <= edone_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        head_reg     <= head_next;
        seek_reg     <= seek_next;
        up_reg       <= up_next;
        edge_reg     <= edge_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/dss_cell.sv -----
// ----------------------------------------------------------------------------
// dss_cell: one cell of a shift / insertion chain
// Holds one entry; takes its left or right neighbor, or the broadcast entry.
// ----------------------------------------------------------------------------
module dss_cell
    import dss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  chain_ctl_t            ctl,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [TRACK_BITS-1:0] new_track,
    input  entry_t                left,
    input  logic                  left_gt,
    input  entry_t                right,
    output entry_t                cur,
    output logic                  gt
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [TRACK_BITS-1:0] track_reg;
    logic [TRACK_BITS-1:0] track_next;

    // empty cells count as larger than anything
    assign gt = !valid_reg || (key_reg > new_key);

    assign cur = '{valid: valid_reg, key: key_reg, track: track_reg};

    // next entry
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        track_next = track_reg;
        if (ctl.push)
        begin
            valid_next = left.valid;
            key_next   = left.key;
            track_next = left.track;
        end
        else if (ctl.pop)
        begin
            valid_next = right.valid;
            key_next   = right.key;
            track_next = right.track;
        end
        else if (ctl.insert && gt)
        begin
            if (left_gt)
            begin
                valid_next = left.valid;
                key_next   = left.key;
                track_next = left.track;
            end
            else
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                track_next = new_track;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        track_reg <= track_next;
    end

endmodule

// ----- rtl/dss_chain.sv -----
// ----------------------------------------------------------------------------
// dss_chain: row of cells forming a stack / sorted insertion chain
// Cell 0 is the output end; entries are kept packed from cell 0 up.
// ----------------------------------------------------------------------------
module dss_chain
    import dss_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  chain_ctl_t            ctl,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [TRACK_BITS-1:0] new_track,
    output entry_t                head,
    output logic                  second_valid
);

    entry_t cells [DEPTH];
    logic   gts   [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_gt_e;

            // cell 0 sees the new entry as its left neighbor
            if (i == 0)
            begin : g_first
                assign left_e    = '{valid: 1'b1, key: new_key, track: new_track};
                assign left_gt_e = 1'b0;
            end
            else
            begin : g_inner
                assign left_e    = cells[i-1];
                assign left_gt_e = gts[i-1];
            end

            // top cell takes an empty entry on pop
            if (i == DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_below
                assign right_e = cells[i+1];
            end

            dss_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .new_key   (new_key),
                .new_track (new_track),
                .left      (left_e),
                .left_gt   (left_gt_e),
                .right     (right_e),
                .cur       (cells[i]),
                .gt        (gts[i])
            );
        end
    endgenerate

    assign head         = cells[0];
    assign second_valid = cells[1].valid;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of disk_seek_scheduler_top
// Drives request words (track, final_req) through FCFS, SCAN and LOOK
// batches and checks every visit word against an in-bench scheduler model.
// Covers register defaults, edge turns, ties, repeats, buffer overflow,
// seek total saturation, back pressure and random batches under idling.
// ----------------------------------------------------------------------------
module tb;
    import dss_pkg::*;

    localparam int QDEPTH         = QUEUE_DEPTH_DEF;
    localparam int TRACK_MAX      = (1 << TRACK_BITS) - 1;
    localparam int SEEK_MAX       = (1 << SEEK_BITS) - 1;
    localparam int DRAIN_CYCLES   = 12;
    localparam int TIMEOUT_CYCLES = 300000;
    // value 3 of the algorithm register: not a defined scheme
    localparam logic [1:0] ALG_UNDEF = 2'd3;

    // clock, reset and DUT ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_word_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_index = CFG_START_TRACK;
    logic [TRACK_BITS-1:0] cfg_wdata = '0;

    // idling controls
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int err_count     = 0;
    int words_seen    = 0;

    // register copies, reset values
    logic [TRACK_BITS-1:0] reg_start    = '0;
    logic                  reg_sweep_up = 1'b1;
    logic [1:0]            reg_alg      = ALG_FCFS;
    logic [TRACK_BITS-1:0] reg_last     = TRACK_MAX;

    // scheduler model state
    int         queued [QDEPTH];
    int         queued_cnt = 0;
    int         model_head = 0;
    int         model_seek = 0;
    logic       queue_ovf  = 1'b0;
    logic       batch_live = 1'b0;
    logic [1:0] batch_alg  = ALG_FCFS;

    out_word_t visit_list[$];
    out_word_t exp_visits[$];

    disk_seek_scheduler_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- model

    // move the head and log one visit word
    task automatic log_visit(input int t, input logic drop);
        out_word_t v;
        int        d;
        int        s;
        d = (t > model_head) ? (t - model_head) : (model_head - t);
        s = model_seek + d;
        if (s > SEEK_MAX)
            s = SEEK_MAX;
        model_seek     = s;
        model_head     = t;
        v.visited      = t[TRACK_BITS-1:0];
        v.seek_total   = s[SEEK_BITS-1:0];
        v.end_of_batch = 1'b0;
        v.dropped      = drop;
        visit_list.push_back(v);
    endtask

    // sorted sweep over the buffered batch
    task automatic plan_sweep();
        int   srt [QDEPTH];
        int   n;
        int   i;
        int   j;
        int   val;
        int   split;
        logic drop;
        logic scan;
        n    = queued_cnt;
        drop = queue_ovf;
        scan = (batch_alg == ALG_SCAN);
        for (i = 0; i < n; i++)
        begin
            val = queued[i];
            j   = i;
            while (j > 0 && srt[j-1] > val)
            begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = val;
        end
        split = 0;
        if (reg_sweep_up)
        begin
            while (split < n && srt[split] < model_head)
                split++;
            for (i = split; i < n; i++)
                log_visit(srt[i], drop);
            if (scan && model_head < int'(reg_last))
                log_visit(int'(reg_last), drop);
            for (i = split; i > 0; i--)
                log_visit(srt[i-1], drop);
        end
        else
        begin
            while (split < n && srt[split] <= model_head)
                split++;
            for (i = split; i > 0; i--)
                log_visit(srt[i-1], drop);
            if (scan && model_head > 0)
                log_visit(0, drop);
            for (i = split; i < n; i++)
                log_visit(srt[i], drop);
        end
    endtask

    // expected visit words caused by one accepted request word
    task automatic predict_request(input in_word_t w);
        out_word_t lastw;
        if (!batch_live)
        begin
            batch_live = 1'b1;
            batch_alg  = (reg_alg == ALG_SCAN || reg_alg == ALG_LOOK) ? reg_alg : ALG_FCFS;
            model_head = int'(reg_start);
            model_seek = 0;
            queued_cnt = 0;
            queue_ovf  = 1'b0;
        end
        visit_list.delete();
        if (batch_alg == ALG_FCFS)
        begin
            log_visit(int'(w.track), 1'b0);
        end
        else
        begin
            if (queued_cnt < QDEPTH)
            begin
                queued[queued_cnt] = int'(w.track);
                queued_cnt++;
            end
            else
                queue_ovf = 1'b1;
            if (w.final_req)
                plan_sweep();
        end
        if (w.final_req)
        begin
            if (visit_list.size() > 0)
            begin
                lastw = visit_list.pop_back();
                lastw.end_of_batch = 1'b1;
                visit_list.push_back(lastw);
            end
            batch_live = 1'b0;
            model_seek = 0;
            queued_cnt = 0;
            queue_ovf  = 1'b0;
        end
        foreach (visit_list[i])
            exp_visits.push_back(visit_list[i]);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch word %0d %s: got %0d, want %0d", words_seen, field, got, want);
        err_count++;
    endtask

    // receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // compare each accepted visit word with the oldest expectation
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_visits.size() == 0)
            begin
                // no word expected at all
                report_mismatch("unexpected visited", int'(out_data.visited), -1);
            end
            else
            begin
                want = exp_visits.pop_front();
                if (out_data.visited !== want.visited)
                    report_mismatch("visited", int'(out_data.visited),
                                    int'(want.visited));
                if (out_data.seek_total !== want.seek_total)
                    report_mismatch("seek_total", int'(out_data.seek_total),
                                    int'(want.seek_total));
                if (out_data.end_of_batch !== want.end_of_batch)
                    report_mismatch("end_of_batch", int'(out_data.end_of_batch),
                                    int'(want.end_of_batch));
                if (out_data.dropped !== want.dropped)
                    report_mismatch("dropped", int'(out_data.dropped),
                                    int'(want.dropped));
            end
            words_seen++;
        end
    end

    // ---------------------------------------------------------------- drivers

    // offer one request word and wait for its acceptance
    task automatic send_request(input int trk, input logic fin);
        in_word_t w;
        w.track     = trk[TRACK_BITS-1:0];
        w.final_req = fin;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(w);
    endtask

    // pause input until every expected word has come
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (exp_visits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[TRACK_BITS-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_TRACK: reg_start    = val[TRACK_BITS-1:0];
            CFG_SWEEP_UP:    reg_sweep_up = val[0];
            CFG_ALGORITHM:   reg_alg      = val[1:0];
            CFG_LAST_TRACK:  reg_last     = val[TRACK_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int start, input int up, input logic [1:0] alg,
                              input int last);
        write_reg(CFG_START_TRACK, start);
        write_reg(CFG_SWEEP_UP, up);
        write_reg(CFG_ALGORITHM, int'(alg));
        write_reg(CFG_LAST_TRACK, last);
    endtask

    // random track, biased toward the head, the edges and repeats
    function automatic int pick_track(input int prev);
        int v;
        case ($urandom_range(5))
            0, 1: v = int'($urandom_range(TRACK_MAX));
            2:    v = int'(reg_start) + int'($urandom_range(4)) - 2;
            3:    v = prev;
            4:    v = $urandom_range(1) ? TRACK_MAX : 0;
            default: v = int'(reg_last) + int'($urandom_range(4)) - 2;
        endcase
        if (v < 0)
            v = 0;
        if (v > TRACK_MAX)
            v = TRACK_MAX;
        return v;
    endfunction

    function automatic int pick_edge_or_any();
        case ($urandom_range(3))
            0:       return 0;
            1:       return TRACK_MAX;
            default: return int'($urandom_range(TRACK_MAX));
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    // reset values: FCFS from track 0, then SCAN up to the default last track
    task automatic test_defaults();
        send_request(TRACK_MAX, 1'b0);
        send_request(TRACK_MAX, 1'b0);
        send_request(0, 1'b1);
        wait_drain();
        write_reg(CFG_ALGORITHM, int'(ALG_SCAN));
        send_request(10, 1'b0);
        send_request(5, 1'b1);
        wait_drain();
    endtask

    // FCFS single request batch and the undefined algorithm code
    task automatic test_fcfs();
        set_config(TRACK_MAX, 0, ALG_FCFS, 0);
        send_request(TRACK_MAX, 1'b1);
        wait_drain();
        write_reg(CFG_ALGORITHM, int'(ALG_UNDEF));
        send_request(100, 1'b0);
        send_request(0, 1'b1);
        wait_drain();
    endtask

    // SCAN: tie with head, repeats, request past the edge, head at or past edge
    task automatic test_scan();
        set_config(2000, 1, ALG_SCAN, 3000);
        send_request(2000, 1'b0);
        send_request(3000, 1'b0);
        send_request(100, 1'b0);
        send_request(2999, 1'b0);
        send_request(100, 1'b0);
        send_request(TRACK_MAX, 1'b1);
        wait_drain();
        set_config(0, 0, ALG_SCAN, TRACK_MAX);
        send_request(0, 1'b0);
        send_request(50, 1'b1);
        wait_drain();
        set_config(3500, 1, ALG_SCAN, 3000);
        send_request(10, 1'b1);
        wait_drain();
        set_config(1000, 0, ALG_SCAN, TRACK_MAX);
        send_request(1000, 1'b0);
        send_request(1500, 1'b0);
        send_request(500, 1'b1);
        wait_drain();
    endtask

    // LOOK in both directions, ties with the head
    task automatic test_look();
        set_config(1000, 0, ALG_LOOK, TRACK_MAX);
        send_request(1000, 1'b0);
        send_request(200, 1'b0);
        send_request(3000, 1'b1);
        wait_drain();
        write_reg(CFG_SWEEP_UP, 1);
        send_request(999, 1'b0);
        send_request(1001, 1'b0);
        send_request(1000, 1'b1);
        wait_drain();
    endtask

    // buffer full: the final request itself is dropped, service still runs
    task automatic test_buffer_full();
        int i;
        set_config(500, 1, ALG_SCAN, TRACK_MAX);
        for (i = 0; i < QDEPTH + 2; i++)
            send_request(int'($urandom_range(TRACK_MAX)), i == QDEPTH + 1);
        wait_drain();
    endtask

    // long FCFS batch of full strokes until the seek total saturates
    task automatic test_seek_saturation();
        int i;
        set_config(0, 1, ALG_FCFS, TRACK_MAX);
        for (i = 0; i < 70; i++)
            send_request((i % 2 == 0) ? TRACK_MAX : 0, i == 69);
        wait_drain();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        int i;
        set_config(int'($urandom_range(TRACK_MAX)), 1, ALG_FCFS, TRACK_MAX);
        hold_left = 400;
        for (i = 0; i < 24; i++)
            send_request(int'($urandom_range(TRACK_MAX)), i == 23);
        wait_drain();
    endtask

    // random settings and batches, mostly well-formed, some overflowing
    task automatic test_random(input int s_pct, input int r_pct, input int n_items);
        int sent;
        int nb;
        int len;
        int i;
        int trk;
        int algsel;
        logic [1:0] alg;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items)
        begin
            wait_drain();
            algsel = int'($urandom_range(9));
            if (algsel < 3)
                alg = ALG_FCFS;
            else if (algsel < 6)
                alg = ALG_SCAN;
            else if (algsel < 9)
                alg = ALG_LOOK;
            else
                alg = ALG_UNDEF;
            set_config(pick_edge_or_any(), int'($urandom_range(1)), alg, pick_edge_or_any());
            for (nb = int'($urandom_range(1, 3)); nb > 0; nb--)
            begin
                if ($urandom_range(7) == 0)
                    len = int'($urandom_range(QDEPTH + 1, QDEPTH + 4));
                else
                    len = int'($urandom_range(1, 12));
                trk = int'(reg_start);
                for (i = 0; i < len; i++)
                begin
                    trk = pick_track(trk);
                    send_request(trk, i == len - 1);
                end
                sent += len;
            end
        end
        wait_drain();
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        send_idle_pct = 36;
        recv_idle_pct = 58;
        test_defaults();
        test_fcfs();
        test_scan();
        test_look();
        test_buffer_full();
        test_seek_saturation();
        test_random(36, 58, 45);
        test_random(58, 36, 45);
        test_random(0, 0, 45);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        wait_drain();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("[disk_seek_scheduler_top] OK");
        else
            $display("[disk_seek_scheduler_top] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("[disk_seek_scheduler_top] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dss_pkg.sv
rtl/dss_cell.sv
rtl/dss_chain.sv
rtl/disk_seek_scheduler_top.sv
tb/tb.sv
